/* design/mtiu_pkg.sv */
// mtiu_pkg: shared types and constants for the machine trap and interrupt unit
// no dependencies
`default_nettype none
package mtiu_pkg;
	localparam int unsigned QueueDepth = 16;
	localparam int unsigned QidxW = $clog2(QueueDepth);
	localparam int unsigned QcntW = $clog2(QueueDepth + 1);
	localparam int unsigned QentW = 2 + 32 + 64;

	localparam logic [2:0] MODE_READ   = 3'd0;
	localparam logic [2:0] MODE_WRITE  = 3'd1;
	localparam logic [2:0] MODE_RAISE  = 3'd2;
	localparam logic [2:0] MODE_TAKE   = 3'd3;
	localparam logic [2:0] MODE_TRAP   = 3'd4;
	localparam logic [2:0] MODE_RETURN = 3'd5;
	localparam logic [2:0] MODE_TICK   = 3'd6;
	localparam logic [2:0] MODE_CLEAR  = 3'd7;

	localparam logic [11:0] CSR_MSTATUS  = 12'h300;
	localparam logic [11:0] CSR_MIE      = 12'h304;
	localparam logic [11:0] CSR_MTVEC    = 12'h305;
	localparam logic [11:0] CSR_MSCRATCH = 12'h340;
	localparam logic [11:0] CSR_MEPC     = 12'h341;
	localparam logic [11:0] CSR_MCAUSE   = 12'h342;
	localparam logic [11:0] CSR_MTVAL    = 12'h343;
	localparam logic [11:0] CSR_MIP      = 12'h344;

	localparam logic [1:0] KIND_SW  = 2'd0;
	localparam logic [1:0] KIND_TIM = 2'd1;
	localparam logic [1:0] KIND_EXT = 2'd2;

	localparam logic [31:0] BIT_SW  = 32'h8;
	localparam logic [31:0] BIT_TIM = 32'h80;
	localparam logic [31:0] BIT_EXT = 32'h800;
	localparam logic [31:0] ST_MIE  = 32'h8;
	localparam logic [31:0] ST_MPIE = 32'h80;
	localparam logic [31:0] ST_MPP  = 32'h1800;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] csr_addr;
		logic [31:0] write_value;
		logic [1:0]  irq_kind;
		logic [31:0] irq_source;
		logic        trap_is_irq;
		logic [30:0] trap_cause;
		logic [31:0] trap_pc;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] next_pc;
		logic        taken_valid;
		logic [1:0]  taken_kind;
		logic [31:0] taken_source;
		logic [63:0] taken_stamp;
		logic        queue_dropped;
		logic        trap_active_flag;
	} rsp_t;

	function automatic logic [31:0] kind_bit(input logic [1:0] k);
		unique case (k)
			KIND_SW:  return BIT_SW;
			KIND_TIM: return BIT_TIM;
			KIND_EXT: return BIT_EXT;
			default:  return 32'h0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* design/mtiu_if.sv */
// mtiu_req_if / mtiu_rsp_if: valid-ready channels of the trap unit
// depends on mtiu_pkg
`default_nettype none
interface mtiu_req_if;
	logic valid;
	logic ready;
	mtiu_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mtiu_rsp_if;
	logic valid;
	logic ready;
	mtiu_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/mtiu_ram.sv */
// mtiu_ram: generic single-port write, single read port ram, registered read
// no dependencies
`default_nettype none
module mtiu_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/machine_trap_interrupt_unit.sv */
// machine_trap_interrupt_unit: machine-mode csrs, interrupt queue, trap entry and return
// depends on mtiu_pkg, mtiu_if, mtiu_ram
// csr, raise, trap, return, tick, clear and a refused take: run in ST_EXEC, result via ST_DONE
// a granted take scans the queue ram one entry a cycle, reads the picked entry, then moves
//   each later entry down, reading it and then writing it one place lower
// next beat accepted the cycle after the last result enters the output register, not before
// arst_n clears all csrs, the counter and the queue count; the queue ram is not cleared
`default_nettype none
module machine_trap_interrupt_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mtiu_req_if.sink    req,
	mtiu_rsp_if.source  rsp
);
	import mtiu_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_PICK = 3'd3;
	localparam logic [2:0] ST_MOVE = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	req_t req_q;
	rsp_t res_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic [31:0] mstatus_q, mie_q, mtvec_q, mscratch_q, mepc_q, mcause_q, mtval_q;
	logic soft_q;
	logic [31:0] hw_q;
	logic trap_q;
	logic [63:0] cycle_q;
	logic [QcntW-1:0] count_q;

	// scan bookkeeping: first index of each kind, a found flag per kind
	logic [QcntW-1:0] scan_q;
	logic [2:0] found_q;
	logic [QidxW-1:0] first_q [3];
	logic [QidxW-1:0] sel_q;
	logic [QcntW-1:0] mv_q;
	logic mv_rd_q;

	logic we;
	logic [QidxW-1:0] waddr, raddr;
	logic [QentW-1:0] wdata, rdata;

	mtiu_ram #(.Width(QentW), .Depth(QueueDepth)) u_queue (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [31:0] mip;
	assign mip = (soft_q ? BIT_SW : 32'h0) | hw_q;

	logic [1:0] rd_kind;
	assign rd_kind = rdata[QentW-1 -: 2];

	logic take_ok;
	assign take_ok = ((mstatus_q & ST_MIE) != 32'h0) &&
		((mie_q & mip & (BIT_SW | BIT_TIM | BIT_EXT)) != 32'h0) && (count_q != '0);

	logic en_ext, en_sw, en_tim;
	assign en_ext = ((mie_q & mip & BIT_EXT) != 32'h0);
	assign en_sw  = ((mie_q & mip & BIT_SW) != 32'h0);
	assign en_tim = ((mie_q & mip & BIT_TIM) != 32'h0);

	logic [QidxW-1:0] pick;
	always_comb begin
		priority if (en_ext && found_q[2]) begin
			pick = first_q[2];
		end else if (en_sw && found_q[0]) begin
			pick = first_q[0];
		end else if (en_tim && found_q[1]) begin
			pick = first_q[1];
		end else begin
			pick = '0;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// ram port control
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = {req_q.irq_kind, req_q.irq_source, cycle_q};
		raddr = '0;
		unique case (state_q)
			ST_EXEC: begin
				we = (req_q.mode == MODE_RAISE) && (kind_bit(req_q.irq_kind) != 32'h0) &&
					(count_q < QcntW'(QueueDepth));
				waddr = count_q[QidxW-1:0];
			end
			ST_SCAN: raddr = scan_q[QidxW-1:0];
			ST_PICK: raddr = pick;
			ST_MOVE: begin
				raddr = mv_q[QidxW-1:0];
				we = mv_rd_q;
				waddr = mv_q[QidxW-1:0] - QidxW'(1);
				wdata = rdata;
			end
			default: ;
		endcase
	end

	logic [31:0] rd_val;
	always_comb begin
		unique case (req_q.csr_addr)
			CSR_MSTATUS:  rd_val = mstatus_q;
			CSR_MIE:      rd_val = mie_q;
			CSR_MTVEC:    rd_val = mtvec_q;
			CSR_MSCRATCH: rd_val = mscratch_q;
			CSR_MEPC:     rd_val = mepc_q;
			CSR_MCAUSE:   rd_val = mcause_q;
			CSR_MTVAL:    rd_val = mtval_q;
			CSR_MIP:      rd_val = mip;
			default:      rd_val = 32'h0;
		endcase
	end

	logic [31:0] vec_base;
	assign vec_base = (mtvec_q & ~32'h3) +
		((req_q.trap_is_irq && mtvec_q[1:0] == 2'd1) ? {req_q.trap_cause[29:0], 2'b00} : 32'h0);

	always_ff @(posedge clk or negedge arst_n) begin
		rsp_t res_n;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0; res_q <= '0;
			mstatus_q <= '0; mie_q <= '0; mtvec_q <= '0; mscratch_q <= '0;
			mepc_q <= '0; mcause_q <= '0; mtval_q <= '0;
			soft_q <= 1'b0; hw_q <= '0; trap_q <= 1'b0; cycle_q <= '0; count_q <= '0;
			scan_q <= '0; found_q <= '0; mv_q <= '0; mv_rd_q <= 1'b0;
		end else begin
			res_n = res_q;
			// the output register takes a finished result once the last one has gone
			if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_q <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_n = '0;
					res_n.trap_active_flag = trap_q;
					state_q <= ST_DONE;
					unique case (req_q.mode)
						MODE_READ: res_n.read_data = rd_val;
						MODE_WRITE: begin
							unique case (req_q.csr_addr)
								CSR_MSTATUS:  mstatus_q <= req_q.write_value;
								CSR_MIE:      mie_q <= req_q.write_value;
								CSR_MTVEC:    mtvec_q <= req_q.write_value;
								CSR_MSCRATCH: mscratch_q <= req_q.write_value;
								CSR_MEPC:     mepc_q <= req_q.write_value;
								CSR_MCAUSE:   mcause_q <= req_q.write_value;
								CSR_MTVAL:    mtval_q <= req_q.write_value;
								CSR_MIP:      soft_q <= req_q.write_value[3];
								default: ;
							endcase
						end
						MODE_RAISE: begin
							if (kind_bit(req_q.irq_kind) != 32'h0) begin
								if (count_q < QcntW'(QueueDepth)) begin
									count_q <= count_q + QcntW'(1);
									hw_q <= hw_q | kind_bit(req_q.irq_kind);
								end else begin
									res_n.queue_dropped = 1'b1;
								end
							end
						end
						MODE_TAKE: begin
							if (take_ok) begin
								scan_q <= '0;
								found_q <= '0;
								state_q <= ST_SCAN;
							end
						end
						MODE_TRAP: begin
							trap_q <= 1'b1;
							res_n.trap_active_flag = 1'b1;
							mepc_q <= req_q.trap_pc;
							mcause_q <= {req_q.trap_is_irq, req_q.trap_cause};
							mtval_q <= '0;
							mstatus_q <= (mstatus_q & ~(ST_MIE | ST_MPIE | ST_MPP)) |
								(mstatus_q[3] ? ST_MPIE : 32'h0) | ST_MPP;
							res_n.next_pc = vec_base;
						end
						MODE_RETURN: begin
							if (trap_q) begin
								trap_q <= 1'b0;
								res_n.trap_active_flag = 1'b0;
								mstatus_q <= (mstatus_q & ~(ST_MIE | ST_MPP)) |
									(mstatus_q[7] ? ST_MIE : 32'h0) | ST_MPIE;
							end
							res_n.next_pc = mepc_q;
						end
						MODE_TICK: cycle_q <= cycle_q + 64'd1;
						default: begin
							hw_q <= '0;
							count_q <= '0;
						end
					endcase
					res_q <= res_n;
				end
				ST_SCAN: begin
					// read of entry scan_q-1 arrives now
					if (scan_q != '0) begin
						for (int k = 0; k < 3; k++) begin
							if (!found_q[k] && rd_kind == 2'(k)) begin
								found_q[k] <= 1'b1;
								first_q[k] <= QidxW'(scan_q - QcntW'(1));
							end
						end
					end
					if (scan_q == count_q) begin
						state_q <= ST_PICK;
					end else begin
						scan_q <= scan_q + QcntW'(1);
					end
				end
				ST_PICK: begin
					sel_q <= pick;
					if (!mv_rd_q) begin
						// first pass: wait for the registered read of the picked entry
						mv_rd_q <= 1'b1;
					end else begin
						res_n.taken_valid = 1'b1;
						res_n.taken_kind = rd_kind;
						res_n.taken_source = rdata[95:64];
						res_n.taken_stamp = rdata[63:0];
						res_q <= res_n;
						hw_q <= hw_q & ~kind_bit(rd_kind);
						mv_q <= QcntW'(sel_q) + QcntW'(1);
						mv_rd_q <= 1'b0;
						scan_q <= '0;
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					// read entry mv_q, write it one place lower next cycle
					if (mv_rd_q) begin
						mv_q <= mv_q + QcntW'(1);
						mv_rd_q <= 1'b0;
					end else if (mv_q >= count_q) begin
						count_q <= count_q - QcntW'(1);
						state_q <= ST_DONE;
					end else begin
						mv_rd_q <= 1'b1;
					end
				end
				default: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/mtiu_checker.sv */
// mtiu_checker: port-level assertions for machine_trap_interrupt_unit, bound to the top level
// depends on mtiu_pkg
`default_nettype none
module mtiu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire mtiu_pkg::rsp_t rsp_data
);
	import mtiu_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("input taken while busy");
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");
	a_take_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.taken_valid |-> rsp_data.taken_stamp == 64'h0)
		else $error("stamp without take");
	a_trap_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.next_pc != 32'h0 |-> rsp_data.read_data == 32'h0)
		else $error("read data on a trap beat");
endmodule

bind machine_trap_interrupt_unit mtiu_checker u_mtiu_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);
`default_nettype wire

/* bench/machine_trap_interrupt_unit_tb.sv */
// machine_trap_interrupt_unit_tb: random and directed operation beats against a local predictor
// depends on mtiu_pkg, mtiu_if and the machine_trap_interrupt_unit rtl
`timescale 1ns / 1ps
module machine_trap_interrupt_unit_tb;
	import mtiu_pkg::*;

	localparam int unsigned CycleLimit = 400000;

	logic clk;
	logic arst_n;

	mtiu_req_if req_ch ();
	mtiu_rsp_if rsp_ch ();

	machine_trap_interrupt_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// predicted unit state
	logic [31:0] p_status, p_enable, p_tvec, p_scratch, p_epc, p_cause, p_tval;
	logic [31:0] p_soft, p_hw;
	logic p_in_trap;
	logic [63:0] p_cycles;
	logic [1:0] p_qkind [QueueDepth];
	logic [31:0] p_qsrc [QueueDepth];
	logic [63:0] p_qstamp [QueueDepth];
	int unsigned p_qcount;

	req_t pending_ops [$];
	rsp_t expected_rsps [$];
	int unsigned fail_count = 0;
	int unsigned tick_total = 0;
	int unsigned checked_total = 0;
	int unsigned item_total;

	function automatic logic [31:0] irq_bit(input logic [1:0] k);
		case (k)
			KIND_SW: irq_bit = BIT_SW;
			KIND_TIM: irq_bit = BIT_TIM;
			KIND_EXT: irq_bit = BIT_EXT;
			default: irq_bit = 32'h0;
		endcase
	endfunction

	function automatic logic [31:0] mip_word();
		mip_word = (p_soft & BIT_SW) | p_hw;
	endfunction

	function automatic int pick_request();
		logic [1:0] order [3];
		logic [31:0] mip;
		logic [31:0] b;
		mip = mip_word();
		order[0] = KIND_EXT;
		order[1] = KIND_SW;
		order[2] = KIND_TIM;
		if ((p_status & ST_MIE) == 0) return -1;
		if ((p_enable & mip & (BIT_SW | BIT_TIM | BIT_EXT)) == 0) return -1;
		if (p_qcount == 0) return -1;
		for (int p = 0; p < 3; p++) begin
			b = irq_bit(order[p]);
			if ((p_enable & b) == 0 || (mip & b) == 0) continue;
			for (int i = 0; i < p_qcount; i++)
				if (p_qkind[i] == order[p]) return i;
		end
		return 0;
	endfunction

	function automatic rsp_t predict_op(input req_t op);
		rsp_t r;
		int sel;
		logic [31:0] base;
		logic was_enabled;
		r = '0;
		case (op.mode)
			MODE_READ: begin
				case (op.csr_addr)
					CSR_MSTATUS: r.read_data = p_status;
					CSR_MIE: r.read_data = p_enable;
					CSR_MTVEC: r.read_data = p_tvec;
					CSR_MSCRATCH: r.read_data = p_scratch;
					CSR_MEPC: r.read_data = p_epc;
					CSR_MCAUSE: r.read_data = p_cause;
					CSR_MTVAL: r.read_data = p_tval;
					CSR_MIP: r.read_data = mip_word();
					default: r.read_data = '0;
				endcase
			end
			MODE_WRITE: begin
				case (op.csr_addr)
					CSR_MSTATUS: p_status = op.write_value;
					CSR_MIE: p_enable = op.write_value;
					CSR_MTVEC: p_tvec = op.write_value;
					CSR_MSCRATCH: p_scratch = op.write_value;
					CSR_MEPC: p_epc = op.write_value;
					CSR_MCAUSE: p_cause = op.write_value;
					CSR_MTVAL: p_tval = op.write_value;
					CSR_MIP: p_soft = (op.write_value & BIT_SW) | (p_soft & ~BIT_SW);
					default: ;
				endcase
			end
			MODE_RAISE: begin
				if (irq_bit(op.irq_kind) != 0) begin
					if (p_qcount >= QueueDepth) begin
						r.queue_dropped = 1'b1;
					end else begin
						p_qkind[p_qcount] = op.irq_kind;
						p_qsrc[p_qcount] = op.irq_source;
						p_qstamp[p_qcount] = p_cycles;
						p_qcount++;
						p_hw |= irq_bit(op.irq_kind);
					end
				end
			end
			MODE_TAKE: begin
				sel = pick_request();
				if (sel >= 0) begin
					r.taken_valid = 1'b1;
					r.taken_kind = p_qkind[sel];
					r.taken_source = p_qsrc[sel];
					r.taken_stamp = p_qstamp[sel];
					p_hw &= ~irq_bit(p_qkind[sel]);
					for (int i = sel; i + 1 < p_qcount; i++) begin
						p_qkind[i] = p_qkind[i + 1];
						p_qsrc[i] = p_qsrc[i + 1];
						p_qstamp[i] = p_qstamp[i + 1];
					end
					p_qcount--;
				end
			end
			MODE_TRAP: begin
				was_enabled = (p_status & ST_MIE) != 0;
				base = p_tvec & ~32'h3;
				p_in_trap = 1'b1;
				p_epc = op.trap_pc;
				p_cause = op.trap_is_irq ? {1'b1, op.trap_cause} : {1'b0, op.trap_cause};
				p_tval = '0;
				p_status &= ~(ST_MIE | ST_MPIE | ST_MPP);
				if (was_enabled) p_status |= ST_MPIE;
				p_status |= ST_MPP;
				if (op.trap_is_irq && p_tvec[1:0] == 2'd1)
					base = base + {op.trap_cause[29:0], 2'b00};
				r.next_pc = base;
			end
			MODE_RETURN: begin
				if (p_in_trap) begin
					p_in_trap = 1'b0;
					if ((p_status & ST_MPIE) != 0) p_status |= ST_MIE;
					else p_status &= ~ST_MIE;
					p_status |= ST_MPIE;
					p_status &= ~ST_MPP;
				end
				r.next_pc = p_epc;
			end
			MODE_TICK: p_cycles = p_cycles + 64'd1;
			default: begin
				p_hw = '0;
				p_qcount = 0;
			end
		endcase
		r.trap_active_flag = p_in_trap;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h", what, got, want);
		fail_count++;
	endtask

	function automatic req_t random_op();
		req_t op;
		logic [11:0] addrs [8];
		int r;
		addrs = '{CSR_MSTATUS, CSR_MIE, CSR_MTVEC, CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE,
			CSR_MTVAL, CSR_MIP};
		op.mode = 3'($urandom_range(0, 7));
		r = $urandom_range(0, 9);
		// mostly useful setup: raises and takes dominate, a third of write values set the enables
		if (r < 3) op.mode = MODE_RAISE;
		else if (r < 5) op.mode = MODE_TAKE;
		op.csr_addr = ($urandom_range(0, 7) == 0) ? 12'($urandom) : addrs[$urandom_range(0, 7)];
		op.write_value = $urandom;
		if ($urandom_range(0, 2) == 0) op.write_value |= ST_MIE | BIT_SW | BIT_TIM | BIT_EXT;
		op.irq_kind = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		op.irq_source = $urandom;
		op.trap_is_irq = 1'($urandom);
		op.trap_cause = 31'($urandom);
		if ($urandom_range(0, 1)) op.trap_cause = 31'($urandom_range(0, 15));
		op.trap_pc = $urandom;
		// clear is heavy handed, keep it rarer so the queue fills
		if (op.mode == MODE_CLEAR && $urandom_range(0, 3) != 0) op.mode = MODE_RAISE;
		return op;
	endfunction

	function automatic req_t make_op(input logic [2:0] m, input logic [11:0] a,
			input logic [31:0] v);
		req_t op;
		op = '0;
		op.mode = m;
		op.csr_addr = a;
		op.write_value = v;
		return op;
	endfunction

	// driver
	int unsigned drive_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			drive_gap <= $urandom_range(0, 11);
		end else if (!req_ch.valid || req_ch.ready) begin
			if (drive_gap != 0 || pending_ops.size() == 0) begin
				req_ch.valid <= 1'b0;
				if (drive_gap != 0) drive_gap <= drive_gap - 1;
			end else begin
				req_ch.valid <= 1'b1;
				req_ch.data <= pending_ops.pop_front();
				drive_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// predictor runs on each accepted beat
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			expected_rsps.push_back(predict_op(req_ch.data));
	end

	// monitor with random back-pressure
	int unsigned sink_gap;
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			sink_gap <= $urandom_range(0, 11);
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked_total++;
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected beat", 64'(rsp_ch.data.read_data), 64'h0);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.data.read_data !== want.read_data)
						report_mismatch("read_data", 64'(rsp_ch.data.read_data),
							64'(want.read_data));
					if (rsp_ch.data.next_pc !== want.next_pc)
						report_mismatch("next_pc", 64'(rsp_ch.data.next_pc), 64'(want.next_pc));
					if (rsp_ch.data.taken_valid !== want.taken_valid)
						report_mismatch("taken_valid", 64'(rsp_ch.data.taken_valid),
							64'(want.taken_valid));
					if (rsp_ch.data.taken_kind !== want.taken_kind)
						report_mismatch("taken_kind", 64'(rsp_ch.data.taken_kind),
							64'(want.taken_kind));
					if (rsp_ch.data.taken_source !== want.taken_source)
						report_mismatch("taken_source", 64'(rsp_ch.data.taken_source),
							64'(want.taken_source));
					if (rsp_ch.data.taken_stamp !== want.taken_stamp)
						report_mismatch("taken_stamp", rsp_ch.data.taken_stamp, want.taken_stamp);
					if (rsp_ch.data.queue_dropped !== want.queue_dropped)
						report_mismatch("queue_dropped", 64'(rsp_ch.data.queue_dropped),
							64'(want.queue_dropped));
					if (rsp_ch.data.trap_active_flag !== want.trap_active_flag)
						report_mismatch("trap_active_flag", 64'(rsp_ch.data.trap_active_flag),
							64'(want.trap_active_flag));
				end
			end
			if (sink_gap != 0) begin
				rsp_ch.ready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rsp_ch.valid)
					sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end
		end
	end

	always @(posedge clk) begin
		tick_total <= tick_total + 1;
		if (tick_total >= CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		req_t op;
		p_status = '0; p_enable = '0; p_tvec = '0; p_scratch = '0;
		p_epc = '0; p_cause = '0; p_tval = '0; p_soft = '0; p_hw = '0;
		p_in_trap = 1'b0; p_cycles = '0; p_qcount = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: csr extremes, unknown address, pending word, all modes
		pending_ops.push_back(make_op(MODE_WRITE, CSR_MSCRATCH, 32'hffff_ffff));
		pending_ops.push_back(make_op(MODE_READ, CSR_MSCRATCH, 32'h0));
		pending_ops.push_back(make_op(MODE_WRITE, 12'hfff, 32'hdead_beef));
		pending_ops.push_back(make_op(MODE_READ, 12'hfff, 32'h0));
		pending_ops.push_back(make_op(MODE_WRITE, CSR_MIP, 32'hffff_ffff));
		pending_ops.push_back(make_op(MODE_READ, CSR_MIP, 32'h0));
		pending_ops.push_back(make_op(MODE_TAKE, 12'h0, 32'h0));
		pending_ops.push_back(make_op(MODE_WRITE, CSR_MIE, 32'hffff_ffff));
		pending_ops.push_back(make_op(MODE_WRITE, CSR_MSTATUS, ST_MIE));
		op = make_op(MODE_RAISE, 12'h0, 32'h0); op.irq_kind = 2'd3; op.irq_source = 32'h1;
		pending_ops.push_back(op);
		// fill the queue past depth with mixed kinds
		for (int i = 0; i < 18; i++) begin
			op = make_op(MODE_RAISE, 12'h0, 32'h0);
			op.irq_kind = 2'(i % 3);
			op.irq_source = (i == 0) ? 32'hffff_ffff : 32'(i);
			pending_ops.push_back(op);
			if (i == 4) pending_ops.push_back(make_op(MODE_TICK, 12'h0, 32'h0));
		end
		pending_ops.push_back(make_op(MODE_TAKE, 12'h0, 32'h0));
		pending_ops.push_back(make_op(MODE_READ, CSR_MIP, 32'h0));
		pending_ops.push_back(make_op(MODE_WRITE, CSR_MTVEC, 32'hffff_fffd));
		op = make_op(MODE_TRAP, 12'h0, 32'h0); op.trap_is_irq = 1'b1;
		op.trap_cause = 31'h7fff_ffff; op.trap_pc = 32'hffff_ffff;
		pending_ops.push_back(op);
		op.trap_is_irq = 1'b0; op.trap_cause = 31'd2; op.trap_pc = 32'h0;
		pending_ops.push_back(op);
		pending_ops.push_back(make_op(MODE_READ, CSR_MCAUSE, 32'h0));
		pending_ops.push_back(make_op(MODE_RETURN, 12'h0, 32'h0));
		pending_ops.push_back(make_op(MODE_RETURN, 12'h0, 32'h0));
		pending_ops.push_back(make_op(MODE_CLEAR, 12'h0, 32'h0));
		pending_ops.push_back(make_op(MODE_READ, CSR_MIP, 32'h0));

		for (int i = 0; i < 750; i++)
			pending_ops.push_back(random_op());
		item_total = pending_ops.size();

		wait (checked_total >= item_total);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && expected_rsps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
